/* design/hbfr_pkg.sv */
`default_nettype none

package hbfr_pkg;

  // Field and register widths.
  localparam int BYTE_W     = 8;
  localparam int LIMIT_W    = 7;
  localparam int CRC_W      = 16;
  localparam int POS_W      = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Default storage depth of the frame buffer.
  localparam int BUFFER_DEPTH_DEF = 64;

  // Smallest frame that is checked: address, control and two FCS bytes.
  localparam int MIN_FRAME = 4;

  localparam logic [BYTE_W-1:0] FLAG_BYTE = 8'h7E;
  localparam logic [BYTE_W-1:0] ESC_BYTE  = 8'h7D;
  localparam logic [BYTE_W-1:0] ESC_MASK  = 8'h20;
  localparam logic [CRC_W-1:0]  CRC_POLY  = 16'h1021;

  // Register reset values.
  localparam logic [BYTE_W-1:0]  MY_ADDR_RST    = 8'h00;
  localparam logic [BYTE_W-1:0]  PEER_ADDR_RST  = 8'h00;
  localparam logic [BYTE_W-1:0]  BCAST_ADDR_RST = 8'hFF;
  localparam logic [LIMIT_W-1:0] MAX_BYTES_RST  = 7'd64;
  localparam logic [CRC_W-1:0]   CRC_INIT_RST   = 16'hFFFF;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MY_ADDR    = 3'd0,
    CFG_PEER_ADDR  = 3'd1,
    CFG_BCAST_ADDR = 3'd2,
    CFG_MAX_BYTES  = 3'd3,
    CFG_CRC_INIT   = 3'd4
  } cfg_idx_e;

  // Result kinds.
  localparam logic KIND_BYTE  = 1'b0;
  localparam logic KIND_ERROR = 1'b1;

  // Control of the shared CRC unit.
  typedef struct packed {
    logic              load;
    logic              en;
    logic [CRC_W-1:0]  init;
    logic [BYTE_W-1:0] data;
  } crc_ctrl_t;

endpackage

`default_nettype wire

/* design/hbfr_ram.sv */
`default_nettype none

module hbfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* design/hbfr_crc.sv */
`default_nettype none

module hbfr_crc (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire hbfr_pkg::crc_ctrl_t          ctrl_i,
  output logic      [hbfr_pkg::CRC_W-1:0]   crc_o
);

  logic [hbfr_pkg::CRC_W-1:0] crc_q, crc_d;
  logic [hbfr_pkg::CRC_W-1:0] step;

  // One message byte per cycle while en is set, eight shift-and-reduce steps, MSB first.
  always_comb begin
    step = crc_q ^ {ctrl_i.data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (step[hbfr_pkg::CRC_W-1]) begin
        step = {step[hbfr_pkg::CRC_W-2:0], 1'b0} ^ hbfr_pkg::CRC_POLY;
      end else begin
        step = {step[hbfr_pkg::CRC_W-2:0], 1'b0};
      end
    end
    if (ctrl_i.load) begin
      crc_d = ctrl_i.init;
    end else if (ctrl_i.en) begin
      crc_d = step;
    end else begin
      crc_d = crc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= '0;
    end else begin
      crc_q <= crc_d;
    end
  end

  assign crc_o = crc_q;

endmodule

`default_nettype wire

/* design/hdlc_byte_frame_receiver.sv */
`default_nettype none

// Channel  | Direction | Handshake                 | Payload
// ---------+-----------+---------------------------+-----------------------------------------
// input    | in        | in_valid_i / in_stall_o   | rx_byte_i
// output   | out       | out_valid_o / out_stall_i | kind_o, frame_byte_o, position_o,
//          |           |                           | last_o, error_total_o
// config   | in        | cfg_we_i (no handshake)   | cfg_index_i, cfg_data_i
//
// An ordinary word of an open frame under the byte limit is written into the frame buffer
// when it is accepted. A closing flag on an open frame of n >= 4 stored bytes starts a check
// pass through the shared one-byte-a-cycle CRC unit and the single RAM read port; a good
// frame emits its n - 2 words, each one read and then loaded, an error frame one word. The
// input stalls for the whole pass, and the sequencer waits on a stalled output word. Reset
// is asynchronous and active low; the frame buffer has no reset and no clearing pass.

module hdlc_byte_frame_receiver #(
  parameter int BUFFER_DEPTH = hbfr_pkg::BUFFER_DEPTH_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // Received words.
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [hbfr_pkg::BYTE_W-1:0]       rx_byte_i,
  // Result words.
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic                                   kind_o,
  output logic      [hbfr_pkg::BYTE_W-1:0]       frame_byte_o,
  output logic      [hbfr_pkg::POS_W-1:0]        position_o,
  output logic                                   last_o,
  output logic      [hbfr_pkg::CRC_W-1:0]        error_total_o,
  // Configuration writes.
  input  wire logic                              cfg_we_i,
  input  wire logic [hbfr_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [hbfr_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int CW = $clog2(BUFFER_DEPTH + 1);
  localparam int LW = hbfr_pkg::LIMIT_W;
  localparam int BW = hbfr_pkg::BYTE_W;
  localparam int PW = hbfr_pkg::POS_W;
  localparam int RW = hbfr_pkg::CRC_W;

  // Framing modes of the receive path.
  typedef enum logic [3:0] {
    MODE_HUNT = 4'b0001,
    MODE_ADDR = 4'b0010,
    MODE_DATA = 4'b0100,
    MODE_ESC  = 4'b1000
  } mode_e;

  // Frame check sequencer.
  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_CRC     = 5'b00010,
    S_CHECK   = 5'b00100,
    S_EMIT_RD = 5'b01000,
    S_EMIT_WR = 5'b10000
  } seq_e;

  // Configuration registers.
  logic [BW-1:0] my_addr_q, peer_addr_q, bcast_addr_q;
  logic [LW-1:0] max_bytes_q;
  logic [RW-1:0] crc_init_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      my_addr_q    <= hbfr_pkg::MY_ADDR_RST;
      peer_addr_q  <= hbfr_pkg::PEER_ADDR_RST;
      bcast_addr_q <= hbfr_pkg::BCAST_ADDR_RST;
      max_bytes_q  <= hbfr_pkg::MAX_BYTES_RST;
      crc_init_q   <= hbfr_pkg::CRC_INIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        hbfr_pkg::CFG_MY_ADDR:    my_addr_q    <= cfg_data_i[BW-1:0];
        hbfr_pkg::CFG_PEER_ADDR:  peer_addr_q  <= cfg_data_i[BW-1:0];
        hbfr_pkg::CFG_BCAST_ADDR: bcast_addr_q <= cfg_data_i[BW-1:0];
        hbfr_pkg::CFG_MAX_BYTES:  max_bytes_q  <= cfg_data_i[LW-1:0];
        hbfr_pkg::CFG_CRC_INIT:   crc_init_q   <= cfg_data_i[RW-1:0];
        default: ;
      endcase
    end
  end

  // State registers.
  mode_e         mode_q, mode_d;
  logic [CW-1:0] count_q, count_d;
  seq_e          seq_q, seq_d;
  logic [CW-1:0] n_q, n_d;
  logic [CW-1:0] ptr_q, ptr_d;
  logic          rd_vld_q, rd_vld_d;
  logic [CW-1:0] rd_idx_q, rd_idx_d;
  logic [BW-1:0] fcs_hi_q, fcs_hi_d, fcs_lo_q, fcs_lo_d;
  logic [RW-1:0] err_q, err_d;

  // Output register.
  logic          out_valid_q, out_valid_d;
  logic          out_kind_q, out_kind_d;
  logic [BW-1:0] out_byte_q, out_byte_d;
  logic [PW-1:0] out_pos_q, out_pos_d;
  logic          out_last_q, out_last_d;
  logic [RW-1:0] out_total_q, out_total_d;

  logic          in_acc;
  logic          out_free;
  logic          close_go;
  logic [LW-1:0] limit;
  logic [BW-1:0] byte_unesc;
  logic          addr_hit;
  logic [CW-1:0] msg_len;

  logic          ram_we, ram_re;
  logic [BW-1:0] ram_wdata, ram_rdata;

  hbfr_pkg::crc_ctrl_t crc_ctrl;
  logic [RW-1:0]       crc_value;

  assign in_stall_o = (seq_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // The usable stored-byte limit never exceeds the buffer depth.
  assign limit = (max_bytes_q > LW'(BUFFER_DEPTH)) ? LW'(BUFFER_DEPTH) : max_bytes_q;

  assign byte_unesc = (mode_q == MODE_ESC) ? (rx_byte_i ^ hbfr_pkg::ESC_MASK) : rx_byte_i;
  assign addr_hit   = (byte_unesc == my_addr_q) || (byte_unesc == peer_addr_q) ||
                      (byte_unesc == bcast_addr_q);
  assign msg_len    = n_q - CW'(2);

  // Receive framing: flag, escape, address filter and overflow.
  always_comb begin
    mode_d    = mode_q;
    count_d   = count_q;
    ram_we    = 1'b0;
    ram_wdata = byte_unesc;
    close_go  = 1'b0;
    if (in_acc) begin
      if (rx_byte_i == hbfr_pkg::FLAG_BYTE) begin
        // A flag closes whatever frame is open and opens the next one.
        if ((mode_q != MODE_HUNT) && (count_q >= CW'(hbfr_pkg::MIN_FRAME))) begin
          close_go = 1'b1;
        end
        mode_d  = MODE_ADDR;
        count_d = '0;
      end else if (mode_q != MODE_HUNT) begin
        if (rx_byte_i == hbfr_pkg::ESC_BYTE) begin
          mode_d = MODE_ESC;
        end else if (LW'(count_q) >= limit) begin
          // Overflow: the count is kept, but the frame is never checked.
          mode_d = MODE_HUNT;
        end else begin
          ram_we  = 1'b1;
          count_d = count_q + CW'(1);
          if (count_q == '0) begin
            if (addr_hit) begin
              mode_d = MODE_DATA;
            end else begin
              mode_d  = MODE_HUNT;
              count_d = '0;
            end
          end else begin
            mode_d = MODE_DATA;
          end
        end
      end
    end
  end

  // Frame check sequencer: CRC pass over the buffer, then emit pass or one error word.
  always_comb begin
    seq_d       = seq_q;
    n_d         = n_q;
    ptr_d       = ptr_q;
    rd_vld_d    = 1'b0;
    rd_idx_d    = ptr_q;
    fcs_hi_d    = fcs_hi_q;
    fcs_lo_d    = fcs_lo_q;
    err_d       = err_q;
    ram_re      = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    out_kind_d  = out_kind_q;
    out_byte_d  = out_byte_q;
    out_pos_d   = out_pos_q;
    out_last_d  = out_last_q;
    out_total_d = out_total_q;

    crc_ctrl      = '0;
    crc_ctrl.init = crc_init_q;
    crc_ctrl.data = ram_rdata;

    case (seq_q)
      S_IDLE: begin
        if (close_go) begin
          crc_ctrl.load = 1'b1;
          n_d           = count_q;
          ptr_d         = '0;
          seq_d         = S_CRC;
        end
      end
      S_CRC: begin
        if (ptr_q != n_q) begin
          ram_re   = 1'b1;
          rd_vld_d = 1'b1;
          ptr_d    = ptr_q + CW'(1);
        end
        if (rd_vld_q) begin
          if (rd_idx_q < msg_len) begin
            crc_ctrl.en = 1'b1;
          end else if (rd_idx_q == msg_len) begin
            fcs_hi_d = ram_rdata;
          end else begin
            fcs_lo_d = ram_rdata;
            seq_d    = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (crc_value == {fcs_hi_q, fcs_lo_q}) begin
          ptr_d = '0;
          seq_d = S_EMIT_RD;
        end else if (out_free) begin
          err_d       = err_q + RW'(1);
          out_valid_d = 1'b1;
          out_kind_d  = hbfr_pkg::KIND_ERROR;
          out_byte_d  = '0;
          out_pos_d   = '0;
          out_last_d  = 1'b1;
          out_total_d = err_q + RW'(1);
          seq_d       = S_IDLE;
        end
      end
      S_EMIT_RD: begin
        ram_re = 1'b1;
        seq_d  = S_EMIT_WR;
      end
      S_EMIT_WR: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = hbfr_pkg::KIND_BYTE;
          out_byte_d  = ram_rdata;
          out_pos_d   = PW'(ptr_q);
          out_last_d  = (ptr_q == msg_len - CW'(1));
          out_total_d = err_q;
          if (ptr_q == msg_len - CW'(1)) begin
            seq_d = S_IDLE;
          end else begin
            ptr_d = ptr_q + CW'(1);
            seq_d = S_EMIT_RD;
          end
        end
      end
      default: begin
        seq_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_HUNT;
      count_q     <= '0;
      seq_q       <= S_IDLE;
      n_q         <= '0;
      ptr_q       <= '0;
      rd_vld_q    <= 1'b0;
      rd_idx_q    <= '0;
      err_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      count_q     <= count_d;
      seq_q       <= seq_d;
      n_q         <= n_d;
      ptr_q       <= ptr_d;
      rd_vld_q    <= rd_vld_d;
      rd_idx_q    <= rd_idx_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fcs_hi_q    <= fcs_hi_d;
    fcs_lo_q    <= fcs_lo_d;
    out_kind_q  <= out_kind_d;
    out_byte_q  <= out_byte_d;
    out_pos_q   <= out_pos_d;
    out_last_q  <= out_last_d;
    out_total_q <= out_total_d;
  end

  hbfr_ram #(
    .WIDTH (BW),
    .DEPTH (BUFFER_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ptr_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  hbfr_crc u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (crc_ctrl),
    .crc_o  (crc_value)
  );

  assign out_valid_o   = out_valid_q;
  assign kind_o        = out_kind_q;
  assign frame_byte_o  = out_byte_q;
  assign position_o    = out_pos_q;
  assign last_o        = out_last_q;
  assign error_total_o = out_total_q;

  // The buffer is only written while no check pass is reading it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (seq_q == S_IDLE))
    else $error("frame buffer written during a check pass");

  // The stored count never runs past the buffer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(BUFFER_DEPTH))
    else $error("stored byte count beyond buffer depth");

  // The read pointer stays within the frame being checked.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q == S_CRC) |-> (ptr_q <= n_q))
    else $error("check pass read past the frame");

  // The error counter moves only together with a freshly loaded error report.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q != $past(err_q)) |-> (out_valid_q && out_kind_q && out_last_q))
    else $error("error count changed without an error report");

endmodule

`default_nettype wire
